[design/bitmap_first_free_allocator_macros.svh]
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define BFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// holds in the cycle after reset is seen
`define BFA_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

[design/bfa_pkg.sv]
package bfa_pkg;

    localparam int WORDS_DEFAULT = 128;
    localparam int ADDR_WORDS    = 128;
    localparam int WORD_BITS     = 32;
    localparam int POS_W         = 5;
    localparam int OP_W          = 3;
    localparam int INDEX_W       = 12;
    localparam int CFG_W         = 8;
    localparam int WORD_IDX_W    = 7;
    localparam int GROUP_W       = 16;
    localparam int GROUP_IDX_W   = 4;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = 1;
    localparam int Q_CNT_W       = 2;

    localparam logic [CFG_W-1:0]     CFG_RESET = 8'd128;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_TEST      = 3'd2,
        OP_FIND      = 3'd3,
        OP_ALLOC     = 3'd4,
        OP_CLEAR_ALL = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CMD_SET,
        CMD_CLEAR,
        CMD_TEST,
        CMD_FIND,
        CMD_ALLOC,
        CMD_CLEAR_ALL,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic                    oor;
        logic [WORD_IDX_W-1:0]   word;
        logic [POS_W-1:0]        pos;
    } cmd_t;

    typedef struct packed {
        logic                    bit_value;
        logic                    found;
        logic [INDEX_W-1:0]      found_index;
        logic                    out_of_range;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RMW,
        BK_SCAN,
        BK_PICK
    } back_state_t;

endpackage

[design/bitmap_first_free_allocator.sv]
// Bitmap allocator over up to 128 words of 32 bits, one result per transfer.
// The front stage registers words_in_use (clamped to the storage size) and
// decodes each transfer into a command that waits in a two-entry queue; the
// back stage executes one command at a time against a single-port-read RAM.
// Set, clear and test read the word in the idle state, then use it in the RMW
// state, where set and clear write it back; an index beyond the words in use,
// clear all and the unused codes answer from the idle state. Find and allocate
// scan a per-word full summary 16 words per cycle, then the chosen word
// is read and its lowest zero bit picked. Reset clears the summary and the
// per-word valid bits at once, so no clearing pass follows reset. A result
// waiting on m_ready does not stop the front from taking up to two more.
module bitmap_first_free_allocator import bfa_pkg::*; #(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [INDEX_W-1:0] s_bit_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_bit_value,
    output logic               m_found,
    output logic [INDEX_W-1:0] m_found_index,
    output logic               m_out_of_range
);

    logic             q_full;
    logic             push;
    cmd_t             push_cmd;
    logic [CFG_W-1:0] live_words;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_cmd;

    bfa_front #(
        .WORDS (WORDS)
    ) u_bfa_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_bit_index (s_bit_index),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .live_words  (live_words)
    );

    bfa_queue u_bfa_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    bfa_back #(
        .WORDS (WORDS)
    ) u_bfa_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .live_words     (live_words),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bit_value    (m_bit_value),
        .m_found        (m_found),
        .m_found_index  (m_found_index),
        .m_out_of_range (m_out_of_range)
    );

endmodule

[design/bfa_ram.sv]
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bfa_front.sv]
module bfa_front import bfa_pkg::*; #(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [INDEX_W-1:0] s_bit_index,
    input  logic               q_full,
    output logic               push,
    output cmd_t               push_cmd,
    output logic [CFG_W-1:0]   live_words
);

    localparam int DEPTH = (WORDS < ADDR_WORDS) ? WORDS : ADDR_WORDS;

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            cfg_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign live_words = (cfg_reg > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : cfg_reg;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        push_cmd.word = s_bit_index[INDEX_W-1:POS_W];
        push_cmd.pos  = s_bit_index[POS_W-1:0];
        push_cmd.oor  = 1'b0;
        unique case (s_operation)
            OP_SET: begin
                push_cmd.kind = CMD_SET;
                push_cmd.oor  = CFG_W'(push_cmd.word) >= live_words;
            end
            OP_CLEAR: begin
                push_cmd.kind = CMD_CLEAR;
                push_cmd.oor  = CFG_W'(push_cmd.word) >= live_words;
            end
            OP_TEST: begin
                push_cmd.kind = CMD_TEST;
                push_cmd.oor  = CFG_W'(push_cmd.word) >= live_words;
            end
            OP_FIND:      push_cmd.kind = CMD_FIND;
            OP_ALLOC:     push_cmd.kind = CMD_ALLOC;
            OP_CLEAR_ALL: push_cmd.kind = CMD_CLEAR_ALL;
            default:      push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

[design/bfa_queue.sv]
module bfa_queue import bfa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/bfa_back.sv]
module bfa_back import bfa_pkg::*; #(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [CFG_W-1:0]   live_words,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_bit_value,
    output logic               m_found,
    output logic [INDEX_W-1:0] m_found_index,
    output logic               m_out_of_range
);

    localparam int DEPTH = (WORDS < ADDR_WORDS) ? WORDS : ADDR_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NG    = (DEPTH + GROUP_W - 1) / GROUP_W;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW  = NG * GROUP_W;

    back_state_t           state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [GW-1:0]         grp_reg, grp_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [DEPTH-1:0]      full_reg, full_next;
    logic                  rd_valid_reg;
    result_t               res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [WORD_BITS-1:0]  word_val;
    logic [WORD_BITS-1:0]  new_word;
    logic [WORD_BITS-1:0]  bit_mask;
    logic [PADW-1:0]       full_pad;
    logic [GROUP_W-1:0]    grp_bits;
    logic [GROUP_W-1:0]    cand;
    logic [GROUP_IDX_W-1:0] cand_enc;
    logic [WORD_IDX_W-1:0] scan_word;
    logic [POS_W-1:0]      zero_pos;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bfa_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written words read as zero
    assign word_val = rd_valid_reg ? ram_rdata : '0;

    // words past the storage count as full
    assign full_pad = ~(PADW'(~full_reg));
    assign grp_bits = full_pad[grp_reg * GROUP_W +: GROUP_W];

    always_comb begin
        for (int j = 0; j < GROUP_W; j++) begin
            cand[j] = !grp_bits[j] &&
                      (CFG_W'({grp_reg, GROUP_IDX_W'(j)}) < live_words);
        end
        cand_enc = '0;
        for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                cand_enc = GROUP_IDX_W'(j);
            end
        end
        zero_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word_val[b]) begin
                zero_pos = POS_W'(b);
            end
        end
    end

    assign scan_word = WORD_IDX_W'({grp_reg, cand_enc});

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        grp_next       = grp_reg;
        word_next      = word_reg;
        valid_next     = valid_reg;
        full_next      = full_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cmd_reg.word[AW-1:0];
        ram_raddr      = q_cmd.word[AW-1:0];
        bit_mask       = WORD_BITS'(1) << cmd_reg.pos;
        new_word       = word_val;

        if (res_valid_reg && m_ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && (!res_valid_reg || m_ready)) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    res_next = '0;
                    unique case (q_cmd.kind) inside
                        CMD_SET, CMD_CLEAR, CMD_TEST: begin
                            if (q_cmd.oor) begin
                                res_next.out_of_range = 1'b1;
                                res_valid_next        = 1'b1;
                            end else begin
                                state_next = BK_RMW;
                            end
                        end
                        CMD_FIND, CMD_ALLOC: begin
                            grp_next   = '0;
                            state_next = BK_SCAN;
                        end
                        CMD_CLEAR_ALL: begin
                            for (int w = 0; w < DEPTH; w++) begin
                                if (CFG_W'(w) < live_words) begin
                                    valid_next[w] = 1'b0;
                                    full_next[w]  = 1'b0;
                                end
                            end
                            res_valid_next = 1'b1;
                        end
                        default: begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            BK_RMW: begin
                res_next                = '0;
                res_next.bit_value      = word_val[cmd_reg.pos];
                res_valid_next          = 1'b1;
                state_next              = BK_IDLE;
                if (cmd_reg.kind == CMD_SET) begin
                    new_word = word_val | bit_mask;
                end else if (cmd_reg.kind == CMD_CLEAR) begin
                    new_word = word_val & ~bit_mask;
                end
                if (cmd_reg.kind != CMD_TEST) begin
                    ram_we                = 1'b1;
                    valid_next[ram_waddr] = 1'b1;
                    full_next[ram_waddr]  = new_word == FULL_WORD;
                end
            end
            BK_SCAN: begin
                ram_raddr = scan_word[AW-1:0];
                if (|cand) begin
                    word_next  = scan_word;
                    state_next = BK_PICK;
                end else if (grp_reg == GW'(NG - 1)) begin
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end else begin
                    grp_next = grp_reg + GW'(1);
                end
            end
            BK_PICK: begin
                res_next             = '0;
                res_next.found       = 1'b1;
                res_next.found_index = {word_reg, zero_pos};
                res_valid_next       = 1'b1;
                state_next           = BK_IDLE;
                ram_waddr            = word_reg[AW-1:0];
                if (cmd_reg.kind == CMD_ALLOC) begin
                    new_word              = word_val | (WORD_BITS'(1) << zero_pos);
                    ram_we                = 1'b1;
                    valid_next[ram_waddr] = 1'b1;
                    full_next[ram_waddr]  = new_word == FULL_WORD;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        ram_wdata = new_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            full_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            full_reg      <= full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        grp_reg      <= grp_next;
        word_reg     <= word_next;
        res_reg      <= res_next;
        rd_valid_reg <= valid_reg[ram_raddr];
    end

    assign m_valid        = res_valid_reg;
    assign m_bit_value    = res_reg.bit_value;
    assign m_found        = res_reg.found;
    assign m_found_index  = res_reg.found_index;
    assign m_out_of_range = res_reg.out_of_range;

endmodule

[design/bfa_checker.sv]
`include "bitmap_first_free_allocator_macros.svh"

module bfa_checker import bfa_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_bit_value,
    input logic               m_found,
    input logic [INDEX_W-1:0] m_found_index,
    input logic               m_out_of_range
);

    `BFA_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found_index) && $stable(m_found) && $stable(m_bit_value) && $stable(m_out_of_range), "result changed while stalled")

    `BFA_ASSERT_NOW(a_oor_alone, aclk, aresetn, m_valid && m_out_of_range, !m_found && !m_bit_value && m_found_index == '0, "out of range result carries other fields")

    `BFA_ASSERT_NOW(a_index_needs_found, aclk, aresetn, m_valid && !m_found, m_found_index == '0, "index without a found bit")

    `BFA_ASSERT_AFTER_RESET(a_quiet_after_reset, aclk, aresetn, !m_valid, "result valid right after reset")

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (.*);
